// ----- design/u8u16_pkg.sv -----
package u8u16_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int MAX_UNITS_WIDTH = 16;
    localparam int UNITS_OUT_WIDTH = 16;
    localparam int ACC_WIDTH = 21;

    localparam logic [MAX_UNITS_WIDTH-1:0] MAX_UNITS_RESET = 16'd8000;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;
    localparam logic [1:0] ST_TOO_LONG  = 2'd3;

    localparam logic [ACC_WIDTH-1:0] CP_MAX        = 21'h10FFFF;
    localparam logic [ACC_WIDTH-1:0] CP_SURR_LOW   = 21'h00D800;
    localparam logic [ACC_WIDTH-1:0] CP_SURR_END   = 21'h00E000;
    localparam logic [ACC_WIDTH-1:0] CP_BMP_MAX    = 21'h00FFFF;
    localparam logic [ACC_WIDTH-1:0] CP_SPACE      = 21'h000020;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_word_t;

    typedef struct packed {
        logic [UNITS_OUT_WIDTH-1:0] utf16_units;
        logic [1:0]                 status;
    } result_t;

endpackage

// ----- design/u8u16_decoder.sv -----
module u8u16_decoder #(
    parameter int COUNT_WIDTH = u8u16_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       advance,
    input  u8u16_pkg::byte_word_t                      word_in,
    input  logic [u8u16_pkg::MAX_UNITS_WIDTH-1:0]      max_units,
    output u8u16_pkg::result_t                         result
);

    localparam int CMP_W = (COUNT_WIDTH > u8u16_pkg::MAX_UNITS_WIDTH) ?
                           COUNT_WIDTH : u8u16_pkg::MAX_UNITS_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [1:0]                          pend_reg, pend_next;
    logic [1:0]                          seq_reg, seq_next;
    logic [u8u16_pkg::ACC_WIDTH-1:0]     acc_reg, acc_next;
    logic [COUNT_WIDTH-1:0]              total_reg, total_next;
    logic [COUNT_WIDTH-1:0]              kept_reg, kept_next;
    logic [1:0]                          err_reg, err_next;

    logic [7:0]                          b;
    logic                                finish;
    logic [COUNT_WIDTH:0]                sum;
    logic [CMP_W-1:0]                    kept_cmp;

    assign b = word_in.data_byte;

    always_comb
    begin
        pend_next  = pend_reg;
        seq_next   = seq_reg;
        acc_next   = acc_reg;
        total_next = total_reg;
        kept_next  = kept_reg;
        err_next   = err_reg;
        finish     = 1'b0;
        sum        = '0;

        if (err_reg == u8u16_pkg::ST_OK)
        begin
            if (pend_reg == 2'd0)
            begin
                if (b[7] == 1'b0)
                begin
                    acc_next = {13'd0, b};
                    seq_next = 2'd0;
                    finish   = 1'b1;
                end
                else if (b[7:5] == 3'b110)
                begin
                    acc_next  = {16'd0, b[4:0]};
                    pend_next = 2'd1;
                    seq_next  = 2'd1;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    acc_next  = {17'd0, b[3:0]};
                    pend_next = 2'd2;
                    seq_next  = 2'd2;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    acc_next  = {18'd0, b[2:0]};
                    pend_next = 2'd3;
                    seq_next  = 2'd3;
                end
                else
                begin
                    err_next = u8u16_pkg::ST_MALFORMED;
                end
            end
            else if (b[7:6] != 2'b10)
            begin
                err_next = u8u16_pkg::ST_MALFORMED;
            end
            else
            begin
                acc_next  = {acc_reg[u8u16_pkg::ACC_WIDTH-7:0], b[5:0]};
                pend_next = pend_reg - 2'd1;
                finish    = (pend_next == 2'd0);
            end

            if (finish)
            begin
                if (acc_next == '0 || acc_next > u8u16_pkg::CP_MAX ||
                    (acc_next >= u8u16_pkg::CP_SURR_LOW && acc_next < u8u16_pkg::CP_SURR_END))
                begin
                    err_next = u8u16_pkg::ST_INVALID;
                end
                else
                begin
                    sum = {1'b0, total_reg} +
                          ((acc_next <= u8u16_pkg::CP_BMP_MAX) ?
                           (COUNT_WIDTH+1)'(1) : (COUNT_WIDTH+1)'(2));
                    total_next = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
                    if (!(seq_next == 2'd0 && acc_next == u8u16_pkg::CP_SPACE))
                    begin
                        kept_next = total_next;
                    end
                end
            end

            if (word_in.last_byte && err_next == u8u16_pkg::ST_OK && pend_next != 2'd0)
            begin
                err_next = u8u16_pkg::ST_MALFORMED;
            end
        end
    end

    assign kept_cmp = CMP_W'(kept_next);

    always_comb
    begin
        if (err_next != u8u16_pkg::ST_OK)
        begin
            result.status      = err_next;
            result.utf16_units = '0;
        end
        else
        begin
            result.status      = (kept_cmp > CMP_W'(max_units)) ?
                                 u8u16_pkg::ST_TOO_LONG : u8u16_pkg::ST_OK;
            result.utf16_units = (kept_cmp > CMP_W'(16'hFFFF)) ?
                                 16'hFFFF : kept_cmp[u8u16_pkg::UNITS_OUT_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            seq_reg   <= '0;
            acc_reg   <= '0;
            total_reg <= '0;
            kept_reg  <= '0;
            err_reg   <= u8u16_pkg::ST_OK;
        end
        else if (advance)
        begin
            if (word_in.last_byte)
            begin
                pend_reg  <= '0;
                seq_reg   <= '0;
                acc_reg   <= '0;
                total_reg <= '0;
                kept_reg  <= '0;
                err_reg   <= u8u16_pkg::ST_OK;
            end
            else
            begin
                pend_reg  <= pend_next;
                seq_reg   <= seq_next;
                acc_reg   <= acc_next;
                total_reg <= total_next;
                kept_reg  <= kept_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

// ----- design/utf8_to_utf16_length_check_unit.sv -----
// A string's last word sits in the input register, then its result in the output register.
// Throughput: one word per cycle unless a last word stalls; the decoder updates once per word.
// A result waiting on m_tready stalls the input only when another last word is ready to finish.
// Reset (rst_n, asynchronous, active low) empties both registers, clears the string state
// and sets max_units to 8000.
module utf8_to_utf16_length_check_unit #(
    parameter int COUNT_WIDTH = u8u16_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,   // data_byte[7:0]
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [23:0]                           m_tdata,   // status[1:0], utf16_units[17:2]
    input  logic                                  cfg_write_en,
    input  logic [u8u16_pkg::MAX_UNITS_WIDTH-1:0] cfg_write_data
);

    logic                                  in_valid_reg;
    u8u16_pkg::byte_word_t                 in_word_reg;
    logic                                  out_valid_reg;
    u8u16_pkg::result_t                    out_result_reg;
    logic [u8u16_pkg::MAX_UNITS_WIDTH-1:0] max_units_reg;
    logic                                  advance;
    u8u16_pkg::result_t                    result;

    assign advance  = in_valid_reg && (!in_word_reg.last_byte || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_result_reg.utf16_units, out_result_reg.status};

    u8u16_decoder #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .word_in   (in_word_reg),
        .max_units (max_units_reg),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_units_reg <= u8u16_pkg::MAX_UNITS_RESET;
        end
        else if (cfg_write_en)
        begin
            max_units_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_word_reg.data_byte <= s_tdata;
            in_word_reg.last_byte <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_word_reg.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_word_reg.last_byte)
        begin
            out_result_reg <= result;
        end
    end

endmodule
